### rtl/cfe_pkg.sv
`timescale 1ns / 1ps

package cfe_pkg;

	// field widths
	localparam int POS_W  = 13;
	localparam int BYTE_W = 8;

	// block code that forces a block to close
	localparam logic [BYTE_W-1:0] FULL_CODE  = 8'hFF;
	localparam logic [BYTE_W-1:0] FIRST_CODE = 8'h01;

	// default size of the encoded-frame buffer
	localparam int OUT_BUFFER_SIZE_DEF = 8192;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// one raw byte request
	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              end_of_frame;
	} in_t;

	// one positioned write
	typedef struct packed {
		logic [POS_W-1:0]  write_position;
		logic [BYTE_W-1:0] write_value;
		logic              last_of_run;
		logic              frame_done;
		logic [POS_W-1:0]  encoded_length;
		logic              overflow;
	} out_t;

	// all writes caused by one byte: first always, second when two is set
	typedef struct packed {
		logic two;
		out_t first;
		out_t second;
	} cmd_t;

endpackage

### rtl/cfe_front.sv
`timescale 1ns / 1ps

module cfe_front #(
	parameter int OUT_BUFFER_SIZE = cfe_pkg::OUT_BUFFER_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  cfe_pkg::in_t  data,
	output cfe_pkg::cmd_t cmd
);

	localparam int POS_W  = cfe_pkg::POS_W;
	localparam int BYTE_W = cfe_pkg::BYTE_W;

	logic [BYTE_W-1:0] block_code_q;
	logic [POS_W-1:0]  code_pos_q;
	logic [POS_W-1:0]  next_pos_q;
	logic              ovf_q;

	logic [BYTE_W-1:0] block_code_d;
	logic [POS_W-1:0]  code_pos_d;
	logic [POS_W-1:0]  next_pos_d;
	logic              ovf_d;

	logic              nz;
	logic              last;
	logic [POS_W:0]    inc1;
	logic [POS_W:0]    inc2;
	logic [BYTE_W-1:0] code_inc;
	logic              full;
	logic              over_next;
	logic              over_code;
	logic              ov0;
	logic              ov_a;
	logic              ov1;
	logic              ov_b;
	logic [POS_W-1:0]  pos0;
	logic [BYTE_W-1:0] val0;
	logic [POS_W-1:0]  pos1;
	logic [BYTE_W-1:0] val1;
	logic              two;

	// position checks against the buffer size
	assign over_next = ({19'd0, next_pos_q} >= 32'(OUT_BUFFER_SIZE));
	assign over_code = ({19'd0, code_pos_q} >= 32'(OUT_BUFFER_SIZE));

	assign nz       = (data.byte_value != '0);
	assign last     = data.end_of_frame;
	assign inc1     = {1'b0, next_pos_q} + 1'b1;
	assign inc2     = {1'b0, inc1[POS_W-1:0]} + 1'b1;
	assign code_inc = block_code_q + 1'b1;
	assign full     = (code_inc == cfe_pkg::FULL_CODE);

	// classify the byte and work out its writes and the next state
	always_comb begin
		pos0         = next_pos_q;
		val0         = data.byte_value;
		pos1         = code_pos_q;
		val1         = code_inc;
		two          = 1'b0;
		ov0          = ovf_q;
		ov_a         = ovf_q;
		ov1          = ovf_q;
		ov_b         = ovf_q;
		block_code_d = block_code_q;
		code_pos_d   = code_pos_q;
		next_pos_d   = next_pos_q;
		if (nz) begin
			// data byte goes to the running position
			ov0  = ovf_q | over_next;
			ov_a = ov0 | inc1[POS_W];
			if (full) begin
				// block reached full size: write its code back
				two          = 1'b1;
				val1         = cfe_pkg::FULL_CODE;
				ov1          = ov_a | over_code;
				block_code_d = cfe_pkg::FIRST_CODE;
				code_pos_d   = inc1[POS_W-1:0];
				if (!last) begin
					next_pos_d = inc2[POS_W-1:0];
					ov_b       = ov1 | inc2[POS_W];
				end else begin
					next_pos_d = inc1[POS_W-1:0];
					ov_b       = ov1;
				end
			end else begin
				block_code_d = code_inc;
				next_pos_d   = inc1[POS_W-1:0];
				if (last) begin
					two  = 1'b1;
					ov1  = ov_a | over_code;
					ov_b = ov1;
				end else begin
					ov_b = ov_a;
				end
			end
		end else begin
			// zero byte closes the block at its reserved slot
			pos0         = code_pos_q;
			val0         = block_code_q;
			ov0          = ovf_q | over_code;
			ov_a         = ov0 | inc1[POS_W];
			block_code_d = cfe_pkg::FIRST_CODE;
			code_pos_d   = next_pos_q;
			next_pos_d   = inc1[POS_W-1:0];
			pos1         = next_pos_q;
			val1         = cfe_pkg::FIRST_CODE;
			if (last) begin
				two  = 1'b1;
				ov1  = ov_a | over_next;
				ov_b = ov1;
			end else begin
				ov_b = ov_a;
			end
		end
		ovf_d = ov_b;
	end

	// pack the command for the queue
	always_comb begin
		cmd                       = '0;
		cmd.two                   = two;
		cmd.first.write_position  = pos0;
		cmd.first.write_value     = val0;
		cmd.first.overflow        = ov0;
		cmd.first.last_of_run     = !two;
		cmd.second.write_position = pos1;
		cmd.second.write_value    = val1;
		cmd.second.overflow       = last ? ov_b : ov1;
		cmd.second.last_of_run    = 1'b1;
		cmd.second.frame_done     = last;
		cmd.second.encoded_length = last ? next_pos_d : '0;
	end

	// encoder state, back to reset values after each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_code_q <= cfe_pkg::FIRST_CODE;
			code_pos_q   <= '0;
			next_pos_q   <= POS_W'(1);
			ovf_q        <= 1'b0;
		end else if (accept) begin
			if (last) begin
				block_code_q <= cfe_pkg::FIRST_CODE;
				code_pos_q   <= '0;
				next_pos_q   <= POS_W'(1);
				ovf_q        <= 1'b0;
			end else begin
				block_code_q <= block_code_d;
				code_pos_q   <= code_pos_d;
				next_pos_q   <= next_pos_d;
				ovf_q        <= ovf_d;
			end
		end
	end

endmodule

### rtl/cfe_queue.sv
`timescale 1ns / 1ps

module cfe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cfe_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output cfe_pkg::cmd_t head
);

	localparam int DEPTH = cfe_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cfe_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/cfe_back.sv
`timescale 1ns / 1ps

module cfe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  cfe_pkg::cmd_t head,
	output logic          pop,
	output logic          wr_valid,
	input  logic          wr_ready,
	output cfe_pkg::out_t wr_data
);

	logic          out_valid_q;
	cfe_pkg::out_t out_data_q;
	logic          sel_q;
	logic          load;

	// output register can take a new write
	assign load = !empty && (!out_valid_q || wr_ready);
	assign pop  = load && (sel_q || !head.two);

	assign wr_valid = out_valid_q;
	assign wr_data  = out_data_q;

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= sel_q ? head.second : head.first;
		end
	end

	// valid flag and which write of the head entry goes next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sel_q       <= !sel_q && head.two;
			end else if (wr_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/cobs_frame_encoder.sv
`timescale 1ns / 1ps
// COBS frame encoder: one raw byte per request, one positioned write per result.
// The writes of a byte are registered first in the command queue, then in the output register.
// Throughput: one byte per cycle while the queue has room; a byte with two writes holds the output
// for both writes, wr_ready low stalls it, and a four-entry queue between classifier and output stage absorbs it.
// Reset (arst_n low) clears encoder state, the queue and the output valid at once.
module cobs_frame_encoder #(
	parameter int OUT_BUFFER_SIZE = cfe_pkg::OUT_BUFFER_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  cfe_pkg::in_t  byte_data,
	output logic          wr_valid,
	input  logic          wr_ready,
	output cfe_pkg::out_t wr_data
);

	logic          accept;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	cfe_pkg::cmd_t cmd;
	cfe_pkg::cmd_t q_head;

	assign byte_ready = !q_full;
	assign accept     = byte_valid && !q_full;

	// classifier and encoder state
	cfe_front #(
		.OUT_BUFFER_SIZE(OUT_BUFFER_SIZE)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.data  (byte_data),
		.cmd   (cmd)
	);

	// command queue
	cfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// write serializer and output register
	cfe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.head    (q_head),
		.pop     (q_pop),
		.wr_valid(wr_valid),
		.wr_ready(wr_ready),
		.wr_data (wr_data)
	);

endmodule
